// ===== src/xcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfp_pkg
// shared types and constants of the xor checked frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package xcfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 8;

    localparam logic [INDEX_W-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [INDEX_W-1:0] REG_HEADER_SECOND = 8'd1;
    localparam logic [INDEX_W-1:0] REG_LED_FUNCTION  = 8'd2;
    localparam logic [INDEX_W-1:0] REG_MAX_LENGTH    = 8'd3;

    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_LED_FUNCTION  = 8'h06;
    localparam logic [BYTE_W-1:0] RST_MAX_LENGTH    = 8'd11;

    localparam logic [BYTE_W-1:0] LED_MIN_LENGTH = 8'd3;

    typedef enum logic [4:0] {
        PH_HUNT_FIRST  = 5'b00001,
        PH_HUNT_SECOND = 5'b00010,
        PH_LENGTH      = 5'b00100,
        PH_BODY        = 5'b01000,
        PH_CHECK       = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] led_function_code;
        logic [BYTE_W-1:0] max_body_length;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/xcfp_regs.sv =====
// ----------------------------------------------------------------------------
// xcfp_regs
// configuration register file, written through the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module xcfp_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [xcfp_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [xcfp_pkg::BYTE_W-1:0]   cfg_data,
    output xcfp_pkg::cfg_t                     cfg
);

    xcfp_pkg::cfg_t cfg_reg;
    xcfp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                xcfp_pkg::REG_HEADER_FIRST:  cfg_next.header_first      = cfg_data;
                xcfp_pkg::REG_HEADER_SECOND: cfg_next.header_second     = cfg_data;
                xcfp_pkg::REG_LED_FUNCTION:  cfg_next.led_function_code = cfg_data;
                xcfp_pkg::REG_MAX_LENGTH:    cfg_next.max_body_length   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first      <= xcfp_pkg::RST_HEADER_FIRST;
            cfg_reg.header_second     <= xcfp_pkg::RST_HEADER_SECOND;
            cfg_reg.led_function_code <= xcfp_pkg::RST_LED_FUNCTION;
            cfg_reg.max_body_length   <= xcfp_pkg::RST_MAX_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/xor_checked_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_core
// byte stream frame parser with two-byte header, length, body and xor checksum
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the s_ channel whenever the
// result register is free or being taken, and emits one m_ transaction for
// each frame whose checksum byte equals the xor of all earlier frame bytes.
// The phase update, body byte capture and running xor sit between the parser
// state registers and the result register, and a byte is accepted while a
// result waits only if that result is taken in the same cycle. Frames with
// a bad second header byte, an oversized length or a bad checksum are dropped
// silently and hunting starts again at the next byte.
`default_nettype none

module xor_checked_frame_parser_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [xcfp_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [xcfp_pkg::BYTE_W-1:0]   cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [xcfp_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [xcfp_pkg::BYTE_W-1:0]        m_func_code,
    output logic [xcfp_pkg::BYTE_W-1:0]        m_led_number,
    output logic                               m_led_on,
    output logic                               m_is_led_command,
    output logic [xcfp_pkg::BYTE_W-1:0]        m_body_length
);

    xcfp_pkg::cfg_t cfg;

    xcfp_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xcfp_pkg::phase_t              phase_reg, phase_next;
    logic [xcfp_pkg::BYTE_W-1:0]   length_reg, length_next;
    logic [xcfp_pkg::BYTE_W-1:0]   seen_reg, seen_next;
    logic [xcfp_pkg::BYTE_W-1:0]   xor_reg, xor_next;
    logic [xcfp_pkg::BYTE_W-1:0]   func_reg, func_next;
    logic [xcfp_pkg::BYTE_W-1:0]   index_reg, index_next;
    logic [xcfp_pkg::BYTE_W-1:0]   state_reg, state_next;

    logic                          m_valid_reg, m_valid_next;
    logic [xcfp_pkg::BYTE_W-1:0]   m_func_reg, m_func_next;
    logic [xcfp_pkg::BYTE_W-1:0]   m_num_reg, m_num_next;
    logic                          m_on_reg, m_on_next;
    logic                          m_led_reg, m_led_next;
    logic [xcfp_pkg::BYTE_W-1:0]   m_len_reg, m_len_next;

    logic                          accept;
    logic                          emit;
    logic [xcfp_pkg::BYTE_W-1:0]   b;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_rx_byte;

    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        xor_next    = xor_reg;
        func_next   = func_reg;
        index_next  = index_reg;
        state_next  = state_reg;
        emit        = 1'b0;
        if (accept) begin
            case (phase_reg)
                xcfp_pkg::PH_HUNT_SECOND: begin
                    if (b == cfg.header_second) begin
                        xor_next   = xor_reg ^ b;
                        phase_next = xcfp_pkg::PH_LENGTH;
                    end else begin
                        phase_next = xcfp_pkg::PH_HUNT_FIRST;
                    end
                end
                xcfp_pkg::PH_LENGTH: begin
                    if (b > cfg.max_body_length) begin
                        phase_next = xcfp_pkg::PH_HUNT_FIRST;
                    end else begin
                        length_next = b;
                        xor_next    = xor_reg ^ b;
                        seen_next   = '0;
                        func_next   = '0;
                        index_next  = '0;
                        state_next  = '0;
                        phase_next  = (b == '0) ? xcfp_pkg::PH_CHECK : xcfp_pkg::PH_BODY;
                    end
                end
                xcfp_pkg::PH_BODY: begin
                    if (seen_reg == 8'd0) begin
                        func_next = b;
                    end else if (seen_reg == 8'd1) begin
                        index_next = b;
                    end else if (seen_reg == 8'd2) begin
                        state_next = b;
                    end
                    xor_next  = xor_reg ^ b;
                    seen_next = seen_reg + 8'd1;
                    if (seen_next >= length_reg) begin
                        phase_next = xcfp_pkg::PH_CHECK;
                    end
                end
                xcfp_pkg::PH_CHECK: begin
                    emit       = (b == xor_reg);
                    phase_next = xcfp_pkg::PH_HUNT_FIRST;
                end
                default: begin
                    if (b == cfg.header_first) begin
                        xor_next   = b;
                        phase_next = xcfp_pkg::PH_HUNT_SECOND;
                    end else begin
                        phase_next = xcfp_pkg::PH_HUNT_FIRST;
                    end
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_func_next  = m_func_reg;
        m_num_next   = m_num_reg;
        m_on_next    = m_on_reg;
        m_led_next   = m_led_reg;
        m_len_next   = m_len_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_func_next  = func_reg;
            m_num_next   = index_reg;
            m_on_next    = (state_reg != '0);
            m_led_next   = (length_reg >= xcfp_pkg::LED_MIN_LENGTH)
                           && (func_reg == cfg.led_function_code);
            m_len_next   = length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= xcfp_pkg::PH_HUNT_FIRST;
            length_reg  <= '0;
            seen_reg    <= '0;
            xor_reg     <= '0;
            func_reg    <= '0;
            index_reg   <= '0;
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
            func_reg    <= func_next;
            index_reg   <= index_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_func_reg <= m_func_next;
        m_num_reg  <= m_num_next;
        m_on_reg   <= m_on_next;
        m_led_reg  <= m_led_next;
        m_len_reg  <= m_len_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_func_code      = m_func_reg;
    assign m_led_number     = m_num_reg;
    assign m_led_on         = m_on_reg;
    assign m_is_led_command = m_led_reg;
    assign m_body_length    = m_len_reg;

endmodule

`default_nettype wire

// ===== sim/tb_xor_checked_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_checked_frame_parser_core
// self-checking bench for the xor checked frame parser
// ----------------------------------------------------------------------------
// Feeds byte streams built from good frames, frames with a bad checksum, a bad
// second header byte, an oversized length, cut-off frames and loose noise.
// A scoreboard class tracks the parser state byte by byte, queues the frame
// each good checksum should produce, and compares every result transaction
// field by field. Runs several register settings, including the extremes,
// under changing sender and receiver stall patterns.
// ----------------------------------------------------------------------------

module tb_xor_checked_frame_parser_core;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 260;

    localparam logic [xcfp_pkg::INDEX_W-1:0] REG_UNUSED = 8'hFF;

    typedef logic [xcfp_pkg::BYTE_W-1:0] octet_q_t[$];

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_SECOND,
        FRAME_TOO_LONG,
        FRAME_CUT
    } frame_kind_t;

    typedef struct packed {
        logic [xcfp_pkg::BYTE_W-1:0] func_code;
        logic [xcfp_pkg::BYTE_W-1:0] led_number;
        logic                        led_on;
        logic                        is_led_command;
        logic [xcfp_pkg::BYTE_W-1:0] body_length;
    } frame_info_t;

    class frame_scoreboard;
        xcfp_pkg::cfg_t              cfg;
        xcfp_pkg::phase_t            phase;
        logic [xcfp_pkg::BYTE_W-1:0] frame_len;
        logic [xcfp_pkg::BYTE_W-1:0] body_count;
        logic [xcfp_pkg::BYTE_W-1:0] xor_acc;
        logic [xcfp_pkg::BYTE_W-1:0] held_func;
        logic [xcfp_pkg::BYTE_W-1:0] held_index;
        logic [xcfp_pkg::BYTE_W-1:0] held_state;
        frame_info_t                 expected_frames[$];
        int                          errors;

        function new();
            cfg = '{xcfp_pkg::RST_HEADER_FIRST, xcfp_pkg::RST_HEADER_SECOND,
                    xcfp_pkg::RST_LED_FUNCTION, xcfp_pkg::RST_MAX_LENGTH};
            phase = xcfp_pkg::PH_HUNT_FIRST;
            frame_len = '0;
            body_count = '0;
            xor_acc = '0;
            held_func = '0;
            held_index = '0;
            held_state = '0;
            errors = 0;
        endfunction

        function void write_register(logic [xcfp_pkg::INDEX_W-1:0] index,
                                     logic [xcfp_pkg::BYTE_W-1:0] value);
            case (index)
                xcfp_pkg::REG_HEADER_FIRST:  cfg.header_first = value;
                xcfp_pkg::REG_HEADER_SECOND: cfg.header_second = value;
                xcfp_pkg::REG_LED_FUNCTION:  cfg.led_function_code = value;
                xcfp_pkg::REG_MAX_LENGTH:    cfg.max_body_length = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endfunction

        // accepted input transaction
        function void note_byte(logic [xcfp_pkg::BYTE_W-1:0] b);
            frame_info_t frame;
            case (phase)
                xcfp_pkg::PH_HUNT_SECOND: begin
                    if (b == cfg.header_second) begin
                        xor_acc ^= b;
                        phase = xcfp_pkg::PH_LENGTH;
                    end else begin
                        phase = xcfp_pkg::PH_HUNT_FIRST;
                    end
                end
                xcfp_pkg::PH_LENGTH: begin
                    if (b > cfg.max_body_length) begin
                        phase = xcfp_pkg::PH_HUNT_FIRST;
                    end else begin
                        frame_len = b;
                        xor_acc ^= b;
                        body_count = '0;
                        held_func = '0;
                        held_index = '0;
                        held_state = '0;
                        phase = (b == '0) ? xcfp_pkg::PH_CHECK : xcfp_pkg::PH_BODY;
                    end
                end
                xcfp_pkg::PH_BODY: begin
                    case (body_count)
                        8'd0: held_func = b;
                        8'd1: held_index = b;
                        8'd2: held_state = b;
                        default: ;
                    endcase
                    xor_acc ^= b;
                    body_count++;
                    if (body_count >= frame_len) phase = xcfp_pkg::PH_CHECK;
                end
                xcfp_pkg::PH_CHECK: begin
                    if (b == xor_acc) begin
                        frame.func_code = held_func;
                        frame.led_number = held_index;
                        frame.led_on = (held_state != '0);
                        frame.is_led_command = (frame_len >= xcfp_pkg::LED_MIN_LENGTH) &&
                                               (held_func == cfg.led_function_code);
                        frame.body_length = frame_len;
                        expected_frames.push_back(frame);
                    end
                    phase = xcfp_pkg::PH_HUNT_FIRST;
                end
                default: begin
                    if (b == cfg.header_first) begin
                        xor_acc = b;
                        phase = xcfp_pkg::PH_HUNT_SECOND;
                    end else begin
                        phase = xcfp_pkg::PH_HUNT_FIRST;
                    end
                end
            endcase
        endfunction

        // accepted result transaction
        function void check_result(frame_info_t got);
            frame_info_t want;
            if (expected_frames.size() == 0) begin
                report($sformatf("unexpected frame func %02h len %0d",
                                 got.func_code, got.body_length));
                return;
            end
            want = expected_frames.pop_front();
            if (got.func_code !== want.func_code)
                report($sformatf("func_code %02h, expected %02h",
                                 got.func_code, want.func_code));
            if (got.led_number !== want.led_number)
                report($sformatf("led_number %02h, expected %02h",
                                 got.led_number, want.led_number));
            if (got.led_on !== want.led_on)
                report($sformatf("led_on %b, expected %b", got.led_on, want.led_on));
            if (got.is_led_command !== want.is_led_command)
                report($sformatf("is_led_command %b, expected %b",
                                 got.is_led_command, want.is_led_command));
            if (got.body_length !== want.body_length)
                report($sformatf("body_length %0d, expected %0d",
                                 got.body_length, want.body_length));
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [xcfp_pkg::INDEX_W-1:0] cfg_index;
    logic [xcfp_pkg::BYTE_W-1:0]  cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [xcfp_pkg::BYTE_W-1:0]  s_rx_byte;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [xcfp_pkg::BYTE_W-1:0]  m_func_code;
    logic [xcfp_pkg::BYTE_W-1:0]  m_led_number;
    logic                         m_led_on;
    logic                         m_is_led_command;
    logic [xcfp_pkg::BYTE_W-1:0]  m_body_length;

    frame_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int sent_count = 0;
    int cycle_count = 0;

    xor_checked_frame_parser_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_func_code      (m_func_code),
        .m_led_number     (m_led_number),
        .m_led_on         (m_led_on),
        .m_is_led_command (m_is_led_command),
        .m_body_length    (m_body_length)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_xor_checked_frame_parser_core NOT OK");
            $finish;
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result('{m_func_code, m_led_number, m_led_on,
                                  m_is_led_command, m_body_length});
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task send_byte(logic [xcfp_pkg::BYTE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(value);
        sent_count++;
    endtask

    task send_frame(frame_kind_t kind, octet_q_t body);
        logic [xcfp_pkg::BYTE_W-1:0] len;
        logic [xcfp_pkg::BYTE_W-1:0] sum;
        int keep;
        len = 8'(body.size());
        send_byte(sb.cfg.header_first);
        if (kind == FRAME_BAD_SECOND) begin
            send_byte(sb.cfg.header_second ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(sb.cfg.header_second);
        if (kind == FRAME_TOO_LONG && sb.cfg.max_body_length != 8'hFF) begin
            send_byte(8'($urandom_range(int'(sb.cfg.max_body_length) + 1, 255)));
            return;
        end
        send_byte(len);
        sum = sb.cfg.header_first ^ sb.cfg.header_second ^ len;
        keep = (kind == FRAME_CUT && len != 0) ? $urandom_range(int'(len) - 1) : int'(len);
        for (int i = 0; i < keep; i++) begin
            send_byte(body[i]);
            sum ^= body[i];
        end
        if (kind == FRAME_CUT) return;
        // oversized length with no room above the limit ends up as a bad checksum
        if (kind != FRAME_GOOD) sum ^= 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task random_traffic(int budget);
        int stop_at;
        int pick;
        int lim;
        int len;
        octet_q_t body;
        frame_kind_t kind;
        stop_at = sent_count + budget;
        while (sent_count < stop_at) begin
            pick = $urandom_range(99);
            lim = int'(sb.cfg.max_body_length);
            if (lim > 16 && $urandom_range(39) == 0)
                len = $urandom_range(lim);
            else if ($urandom_range(4) == 0)
                len = (lim < 16) ? lim : 16;
            else
                len = $urandom_range((lim < 6) ? lim : 6);
            body.delete();
            for (int i = 0; i < len; i++) begin
                if (i == 0 && $urandom_range(9) < 4)
                    body.push_back(sb.cfg.led_function_code);
                else if (i == 2 && $urandom_range(3) == 0)
                    body.push_back(8'h00);
                else
                    body.push_back(8'($urandom_range(255)));
            end
            if (pick < 62) kind = FRAME_GOOD;
            else if (pick < 72) kind = FRAME_BAD_SUM;
            else if (pick < 80) kind = FRAME_BAD_SECOND;
            else if (pick < 86) kind = FRAME_TOO_LONG;
            else if (pick < 93) kind = FRAME_CUT;
            else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                continue;
            end
            send_frame(kind, body);
        end
    endtask

    task wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task cfg_write(logic [xcfp_pkg::INDEX_W-1:0] index, logic [xcfp_pkg::BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(index, value);
    endtask

    task run_phase(xcfp_pkg::cfg_t c, int tx_pct, int rx_pct);
        wait_idle();
        cfg_write(REG_UNUSED, 8'($urandom_range(255)));
        cfg_write(xcfp_pkg::REG_HEADER_FIRST, c.header_first);
        cfg_write(xcfp_pkg::REG_HEADER_SECOND, c.header_second);
        cfg_write(xcfp_pkg::REG_LED_FUNCTION, c.led_function_code);
        cfg_write(xcfp_pkg::REG_MAX_LENGTH, c.max_body_length);
        cfg_valid <= 1'b0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        random_traffic(PHASE_BYTES);
    endtask

    initial begin
        octet_q_t body;
        xcfp_pkg::cfg_t c;
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        tx_idle_pct = 22;
        rx_idle_pct = 47;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // led frame with a body byte past the third
        body = {xcfp_pkg::RST_LED_FUNCTION, 8'hFF, 8'h01, 8'h33};
        send_frame(FRAME_GOOD, body);
        // zero length
        body.delete();
        send_frame(FRAME_GOOD, body);
        // bad second header byte equal to the first header, then a stray second header
        send_byte(xcfp_pkg::RST_HEADER_FIRST);
        send_byte(xcfp_pkg::RST_HEADER_FIRST);
        send_byte(xcfp_pkg::RST_HEADER_SECOND);
        send_frame(FRAME_TOO_LONG, body);
        send_frame(FRAME_BAD_SUM, body);
        // short body with led function code
        body = {xcfp_pkg::RST_LED_FUNCTION, 8'h00};
        send_frame(FRAME_GOOD, body);

        c = '{8'h00, 8'hFF, 8'hFF, 8'hFF};
        run_phase(c, 22, 47);
        c = '{8'hFF, 8'h00, 8'h00, 8'h00};
        run_phase(c, 22, 47);
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(1, 20))};
        run_phase(c, 47, 22);
        c = '{8'h3C, 8'h3C, 8'h80, 8'h03};
        run_phase(c, 47, 22);
        c = '{xcfp_pkg::RST_HEADER_FIRST, xcfp_pkg::RST_HEADER_SECOND,
              xcfp_pkg::RST_LED_FUNCTION, xcfp_pkg::RST_MAX_LENGTH};
        run_phase(c, 0, 0);
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(15))};
        run_phase(c, 0, 0);
        wait_idle();

        if (sb.errors == 0) begin
            $display("tb_xor_checked_frame_parser_core OK");
        end else begin
            $display("tb_xor_checked_frame_parser_core NOT OK");
        end
        $finish;
    end

endmodule
